[hdl/cpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_pkg: shared types and constants for the closest-point-on-ellipse block
// Operation codes and handshake structs of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int COORD_W        = 24;
    localparam int MAX_ITERATIONS = 48;
    localparam int ITER_W         = 8;    // holds MAX_ITERATIONS up to 255
    localparam int WORD_W         = 64;
    localparam int WIDE_W         = 128;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_rsp_t;

endpackage

[hdl/cpe_arith.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_arith: shared radix-2 multiply / divide / square-root unit
// MUL 64x64->128 in 64 steps, DIV 128/64 in 128 steps (saturating),
// SQRT of 128 bits in 64 steps. One adder/subtractor row per step.
// ----------------------------------------------------------------------------
module cpe_arith (
    input  logic                aclk,
    input  logic                aresetn,
    input  cpe_pkg::arith_req_t req,
    input  logic [127:0]        num,    // dividend / radicand / multiplier in [63:0]
    input  logic [63:0]         den,    // divisor / multiplicand
    output cpe_pkg::arith_rsp_t rsp,
    output logic [127:0]        result
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    cpe_pkg::arith_op_t  op_reg, op_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [66:0]         r_reg, r_next;
    logic [127:0]        q_reg, q_next;
    logic [63:0]         d_reg, d_next;

    logic [64:0] mul_sum;
    logic [64:0] div_rs;
    logic [64:0] div_diff;
    logic        div_ge;
    logic [66:0] sq_rem;
    logic [66:0] sq_trial;
    logic [66:0] sq_diff;
    logic        sq_ge;

    assign mul_sum  = {1'b0, r_reg[63:0]} + (q_reg[0] ? {1'b0, d_reg} : 65'd0);
    assign div_rs   = {r_reg[63:0], q_reg[127]};
    assign div_ge   = div_rs >= {1'b0, d_reg};
    assign div_diff = div_rs - {1'b0, d_reg};
    assign sq_rem   = {r_reg[64:0], q_reg[127:126]};
    assign sq_trial = {1'b0, d_reg, 2'b01};
    assign sq_ge    = sq_rem >= sq_trial;
    assign sq_diff  = sq_rem - sq_trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = req.op;
            r_next    = '0;
            case (req.op)
                cpe_pkg::OP_MUL: begin
                    q_next   = {64'd0, num[63:0]};
                    d_next   = den;
                    cnt_next = 7'd63;
                end
                cpe_pkg::OP_DIV: begin
                    q_next   = num;
                    d_next   = den;
                    cnt_next = 7'd127;
                end
                default: begin
                    q_next   = num;
                    d_next   = '0;
                    cnt_next = 7'd63;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                cpe_pkg::OP_MUL: begin
                    r_next = {3'd0, mul_sum[64:1]};
                    q_next = {64'd0, mul_sum[0], q_reg[63:1]};
                end
                cpe_pkg::OP_DIV: begin
                    r_next = div_ge ? {3'd0, div_diff[63:0]} : {3'd0, div_rs[63:0]};
                    q_next = {q_reg[126:0], div_ge};
                end
                default: begin
                    r_next = sq_ge ? sq_diff : sq_rem;
                    q_next = {q_reg[125:0], 2'b00};
                    d_next = {d_reg[62:0], sq_ge};
                end
            endcase
            if (cnt_reg == 7'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= cpe_pkg::OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    always_comb begin
        case (op_reg)
            cpe_pkg::OP_MUL: result = {r_reg[63:0], q_reg[63:0]};
            cpe_pkg::OP_DIV: result = (|q_reg[127:64]) ? {64'd0, {64{1'b1}}}
                                                        : {64'd0, q_reg[63:0]};
            default:         result = {64'd0, d_reg};
        endcase
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

endmodule

[hdl/closest_point_on_ellipse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_ellipse: nearest point on an axis-aligned ellipse
// Bisection on the secular function for a first-quadrant query point, with
// closed forms on the axes. All arithmetic is wide fixed point.
// ----------------------------------------------------------------------------
//
//  channel | ports      | beat contents (low bits first)
//  --------+------------+------------------------------------------------
//  in      | s_t*       | major_axis, minor_axis, query_first, query_second
//  out     | m_t*       | tdata: near_first, near_second; tuser: axes_error
//
//  Flow: one beat at a time; s_tready is high only while idle.
//  One bisection pass is two divides and two squares; the run time of a
//  beat is set by the single radix-2 arithmetic unit. Bad axes or a query
//  point on the second axis skip the shared unit and finish directly.
//  Reset: synchronous, active low; clears control only. No clearing pass.
//  Stalls: a finished result waits in the output register; the next beat is
//  taken meanwhile, and its result waits until the output is free.
// ----------------------------------------------------------------------------
module closest_point_on_ellipse (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // major_axis, minor_axis, query_first, query_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // near_first, near_second
    output logic [0:0]  m_tuser    // axes_error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_MID,
        S_DONE
    } state_t;

    // one entry per use of the shared unit
    typedef enum logic [4:0] {
        K_E0SQ, K_E1SQ, K_P0, K_P1,
        K_U, K_USQ, K_V, K_VSQ, K_W, K_WSQ,
        K_P0SQ, K_P1SQ, K_HYP,
        K_A0, K_A1, K_A0SQ, K_A1SQ,
        K_X0M, K_X0D, K_X1M, K_X1D,
        K_Q, K_QSQ, K_RT, K_X0Q, K_X1R
    } step_t;

    localparam logic [63:0]  ONE_Q32 = 64'h1_0000_0000;
    localparam logic [127:0] ONE_Q64 = {63'd0, 1'b1, 64'd0};
    localparam logic [cpe_pkg::ITER_W-1:0] ITER_LAST =
        cpe_pkg::ITER_W'(cpe_pkg::MAX_ITERATIONS - 1);

    function automatic logic [23:0] sat24(input logic [63:0] v);
        sat24 = (|v[63:24]) ? 24'hFF_FFFF : v[23:0];
    endfunction

    state_t                      state_reg, state_next;
    step_t                       step_reg, step_next;
    logic                        both_reg, both_next;   // both query coords positive
    logic [23:0]                 e0_reg, e0_next, e1_reg, e1_next;
    logic [23:0]                 y0_reg, y0_next, y1_reg, y1_next;
    logic [63:0]                 e0sq_reg, e0sq_next, e1sq_reg, e1sq_next;
    logic [63:0]                 p0_reg, p0_next, p1_reg, p1_next;
    logic [63:0]                 tmp_reg, tmp_next;
    logic [127:0]                sacc_reg, sacc_next;
    logic [63:0]                 a0_reg, a0_next, a1_reg, a1_next;
    logic signed [63:0]          t0_reg, t0_next, t1_reg, t1_next, t_reg, t_next;
    logic [cpe_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic [23:0]                 x0_reg, x0_next, x1_reg, x1_next;
    logic                        err_reg, err_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [47:0]                 m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    cpe_pkg::arith_req_t arith_req;
    cpe_pkg::arith_rsp_t arith_rsp;
    logic [127:0]        arith_num;
    logic [63:0]         arith_den;
    logic [127:0]        res;

    logic [23:0]        in_e0, in_e1, in_y0, in_y1;
    logic signed [63:0] t_mid;
    logic [63:0]        den0, den1;
    logic [127:0]       sum_sq;
    logic [63:0]        neg_sq;

    assign in_e0 = s_tdata[23:0];
    assign in_e1 = s_tdata[47:24];
    assign in_y0 = s_tdata[71:48];
    assign in_y1 = s_tdata[95:72];

    assign t_mid  = t0_reg + $signed({1'b0, 63'(($unsigned(t1_reg - t0_reg)) >> 1)});
    assign den0   = $unsigned(t_reg) + e0sq_reg;
    assign den1   = $unsigned(t_reg) + e1sq_reg;
    assign sum_sq = sacc_reg + res;
    assign neg_sq = 64'd0 - sacc_reg[63:0];

    // operand selection for the shared unit
    always_comb begin
        arith_req.start = (state_reg == S_ISSUE);
        arith_req.op    = cpe_pkg::OP_MUL;
        arith_num       = '0;
        arith_den       = '0;
        case (step_reg)
            K_E0SQ: begin arith_den = 64'(e0_reg);  arith_num = 128'(e0_reg);  end
            K_E1SQ: begin arith_den = 64'(e1_reg);  arith_num = 128'(e1_reg);  end
            K_P0:   begin arith_den = 64'(e0_reg);  arith_num = 128'(y0_reg);  end
            K_P1:   begin arith_den = 64'(e1_reg);  arith_num = 128'(y1_reg);  end
            K_U:    begin arith_den = 64'(y0_reg);  arith_num = 128'(e1_reg);  end
            K_V:    begin arith_den = 64'(y1_reg);  arith_num = 128'(e0_reg);  end
            K_W:    begin arith_den = 64'(e0_reg);  arith_num = 128'(e1_reg);  end
            K_USQ, K_VSQ, K_WSQ, K_QSQ: begin
                arith_den = tmp_reg;
                arith_num = {64'd0, tmp_reg};
            end
            K_P0SQ: begin arith_den = p0_reg; arith_num = {64'd0, p0_reg}; end
            K_P1SQ: begin arith_den = p1_reg; arith_num = {64'd0, p1_reg}; end
            K_HYP: begin
                arith_req.op = cpe_pkg::OP_SQRT;
                arith_num    = sacc_reg;
            end
            K_A0: begin
                arith_req.op = cpe_pkg::OP_DIV;
                arith_num    = {32'd0, p0_reg, 32'd0};
                arith_den    = den0;
            end
            K_A1: begin
                arith_req.op = cpe_pkg::OP_DIV;
                arith_num    = {32'd0, p1_reg, 32'd0};
                arith_den    = den1;
            end
            K_A0SQ: begin arith_den = a0_reg; arith_num = {64'd0, a0_reg}; end
            K_A1SQ: begin arith_den = a1_reg; arith_num = {64'd0, a1_reg}; end
            K_X0M:  begin arith_den = e0sq_reg; arith_num = 128'(y0_reg); end
            K_X1M:  begin arith_den = e1sq_reg; arith_num = 128'(y1_reg); end
            K_X0D: begin
                arith_req.op = cpe_pkg::OP_DIV;
                arith_num    = sacc_reg;
                arith_den    = den0;
            end
            K_X1D: begin
                arith_req.op = cpe_pkg::OP_DIV;
                arith_num    = sacc_reg;
                arith_den    = den1;
            end
            K_Q: begin
                arith_req.op = cpe_pkg::OP_DIV;
                arith_num    = {32'd0, p0_reg, 32'd0};
                arith_den    = e0sq_reg - e1sq_reg;
            end
            K_RT: begin
                // 1 - q^2 in Q0.64
                arith_req.op = cpe_pkg::OP_SQRT;
                arith_num    = {63'd0, (sacc_reg[63:0] == 64'd0), neg_sq};
            end
            K_X0Q:  begin arith_den = 64'(e0_reg); arith_num = {64'd0, tmp_reg}; end
            K_X1R:  begin arith_den = 64'(e1_reg); arith_num = {64'd0, a1_reg};  end
            default: begin arith_den = '0; arith_num = '0; end
        endcase
    end

    cpe_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .num     (arith_num),
        .den     (arith_den),
        .rsp     (arith_rsp),
        .result  (res)
    );

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        both_next     = both_reg;
        e0_next       = e0_reg;
        e1_next       = e1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        e0sq_next     = e0sq_reg;
        e1sq_next     = e1sq_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        tmp_next      = tmp_reg;
        sacc_next     = sacc_reg;
        a0_next       = a0_reg;
        a1_next       = a1_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        t_next        = t_reg;
        iter_next     = iter_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    e0_next   = in_e0;
                    e1_next   = in_e1;
                    y0_next   = in_y0;
                    y1_next   = in_y1;
                    err_next  = 1'b0;
                    both_next = (in_y1 != 24'd0);
                    step_next = K_E0SQ;
                    if (in_e1 == 24'd0 || in_e1 > in_e0) begin
                        x0_next    = '0;
                        x1_next    = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else if (in_y1 != 24'd0 && in_y0 == 24'd0) begin
                        // on the second axis: minor-axis vertex
                        x0_next    = '0;
                        x1_next    = in_e1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (arith_rsp.done) begin
                    state_next = S_ISSUE;
                    case (step_reg)
                        K_E0SQ: begin e0sq_next = res[63:0]; step_next = K_E1SQ; end
                        K_E1SQ: begin e1sq_next = res[63:0]; step_next = K_P0;   end
                        K_P0: begin
                            p0_next = res[63:0];
                            if (both_reg) begin
                                step_next = K_P1;
                            end else if (res[63:0] < e0sq_reg - e1sq_reg) begin
                                step_next = K_Q;
                            end else begin
                                x0_next    = e0_reg;
                                x1_next    = '0;
                                state_next = S_DONE;
                            end
                        end
                        K_P1:   begin p1_next = res[63:0];  step_next = K_U;   end
                        K_U:    begin tmp_next = res[63:0]; step_next = K_USQ; end
                        K_USQ:  begin sacc_next = res;      step_next = K_V;   end
                        K_V:    begin tmp_next = res[63:0]; step_next = K_VSQ; end
                        K_VSQ:  begin sacc_next = sum_sq;   step_next = K_W;   end
                        K_W:    begin tmp_next = res[63:0]; step_next = K_WSQ; end
                        K_WSQ: begin
                            t0_next   = $signed(p1_reg - e1sq_reg);
                            iter_next = '0;
                            if (sacc_reg == res) begin
                                // already on the ellipse
                                x0_next    = y0_reg;
                                x1_next    = y1_reg;
                                state_next = S_DONE;
                            end else if (sacc_reg > res) begin
                                step_next = K_P0SQ;
                            end else begin
                                t1_next    = '0;
                                state_next = S_MID;
                            end
                        end
                        K_P0SQ: begin sacc_next = res;    step_next = K_P1SQ; end
                        K_P1SQ: begin sacc_next = sum_sq; step_next = K_HYP;  end
                        K_HYP: begin
                            t1_next    = $signed(res[63:0] - e1sq_reg);
                            state_next = S_MID;
                        end
                        K_A0: begin a0_next = res[63:0]; step_next = K_A1; end
                        K_A1: begin
                            a1_next = res[63:0];
                            if (a0_reg > ONE_Q32 || res[63:0] > ONE_Q32) begin
                                t0_next   = t_reg;
                                iter_next = iter_reg + 1'b1;
                                if (iter_reg == ITER_LAST) begin
                                    step_next = K_X0M;
                                end else begin
                                    state_next = S_MID;
                                end
                            end else begin
                                step_next = K_A0SQ;
                            end
                        end
                        K_A0SQ: begin sacc_next = res; step_next = K_A1SQ; end
                        K_A1SQ: begin
                            iter_next = iter_reg + 1'b1;
                            if (sum_sq == ONE_Q64) begin
                                step_next = K_X0M;
                            end else begin
                                if (sum_sq > ONE_Q64) begin
                                    t0_next = t_reg;
                                end else begin
                                    t1_next = t_reg;
                                end
                                if (iter_reg == ITER_LAST) begin
                                    step_next = K_X0M;
                                end else begin
                                    state_next = S_MID;
                                end
                            end
                        end
                        K_X0M:  begin sacc_next = res; step_next = K_X0D; end
                        K_X0D:  begin x0_next = sat24(res[63:0]); step_next = K_X1M; end
                        K_X1M:  begin sacc_next = res; step_next = K_X1D; end
                        K_X1D: begin
                            x1_next    = sat24(res[63:0]);
                            state_next = S_DONE;
                        end
                        K_Q:    begin tmp_next = res[63:0]; step_next = K_QSQ; end
                        K_QSQ:  begin sacc_next = res;      step_next = K_RT;  end
                        K_RT:   begin a1_next = res[63:0];  step_next = K_X0Q; end
                        K_X0Q: begin
                            x0_next   = sat24(res[95:32]);
                            step_next = K_X1R;
                        end
                        K_X1R: begin
                            x1_next    = sat24(res[95:32]);
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MID: begin
                t_next = t_mid;
                if (t_mid == t0_reg || t_mid == t1_reg) begin
                    step_next = K_X0M;
                end else begin
                    step_next = K_A0;
                end
                state_next = S_ISSUE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {x1_reg, x0_reg};
                    m_tuser_next  = err_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= K_E0SQ;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            iter_reg     <= iter_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        both_reg    <= both_next;
        e0_reg      <= e0_next;
        e1_reg      <= e1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        e0sq_reg    <= e0sq_next;
        e1sq_reg    <= e1sq_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        tmp_reg     <= tmp_next;
        sacc_reg    <= sacc_next;
        a0_reg      <= a0_next;
        a1_reg      <= a1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        t_reg       <= t_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // bad axes always come with a zero point
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 48'd0))
        else $error("axes error beat with nonzero point");

    // bisection never runs past its bound
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= cpe_pkg::ITER_W'(cpe_pkg::MAX_ITERATIONS))
        else $error("iteration count out of range");

    // the shared unit is only started when free
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_req.start |-> !arith_rsp.busy)
        else $error("arith unit started while busy");

endmodule
